// ----- src/assert_macros.svh -----
// Assertion macros shared by the keystream cipher RTL.
// Expects signals clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while in reset.
`define LSK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge.
`define LSK_NEVER(label, cond, msg) \
	`LSK_ASSERT(label, !(cond), msg)

`endif

// ----- src/lsk_pkg.sv -----
// Package for the lagged-sum keystream cipher: types, constants,
// and the window recurrence function. No dependencies.
package lsk_pkg;

	localparam int WORD_W         = 32;
	localparam int WINDOW_DEPTH   = 6;
	localparam int SHIFT_AMOUNT   = 13;
	localparam int LAG3_FACTOR    = 11;
	localparam int ROUND_CONSTANT = 2017;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_VECTOR = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [WORD_W-1:0] word_t;
	// [0] is the oldest word (n-6), [5] the newest (n-1)
	typedef word_t [WINDOW_DEPTH-1:0] window_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} item_t;

	// head of the request queue as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	function automatic word_t next_word(input window_t win);
		word_t lag3;
		lag3 = WORD_W'(LAG3_FACTOR) * win[3];
		return (win[5] << SHIFT_AMOUNT) + lag3 + win[1] + win[0]
			+ WORD_W'(ROUND_CONSTANT);
	endfunction

endpackage

// ----- src/lsk_front.sv -----
// Front end of the keystream cipher: accepts requests into a short queue.
// Depends on lsk_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lsk_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             restart,
	output lsk_pkg::q_head_t head,
	input  logic             pop
);

	lsk_pkg::item_t                   entry_q [lsk_pkg::QUEUE_DEPTH];
	logic [lsk_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [lsk_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [lsk_pkg::QCNT_W-1:0]       count_q;
	logic                             push;

	assign in_stall = (count_q == lsk_pkg::QCNT_W'(lsk_pkg::QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;

	assign head.valid = (count_q != '0);
	assign head.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{data_byte: data_byte, restart: restart};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`LSK_NEVER(a_pop_empty, pop && (count_q == '0), "pop from empty queue")
	`LSK_ASSERT(a_count_track, (push && !pop) |=> (count_q == $past(count_q) + 1'b1),
		"queue count lost a push")

endmodule

// ----- src/lsk_back.sv -----
// Back end of the keystream cipher: config registers, word window,
// warm-up sequencer and output register. Depends on lsk_pkg, assert_macros.svh.
`include "assert_macros.svh"

module lsk_back #(
	parameter int WARMUP_ROUNDS = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [lsk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lsk_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  lsk_pkg::q_head_t                head,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      result_byte
);

	localparam int CNT_W = $clog2(WARMUP_ROUNDS + 2);

	localparam logic ST_RUN  = 1'b0;
	localparam logic ST_WARM = 1'b1;

	logic [lsk_pkg::CFG_DATA_W-1:0] key_low_q;
	logic [lsk_pkg::CFG_DATA_W-1:0] key_high_q;
	logic [lsk_pkg::CFG_DATA_W-1:0] init_vector_q;

	logic                 state_q;
	logic [CNT_W-1:0]     round_q;
	logic                 warm_done_q;
	lsk_pkg::window_t     win_q;
	lsk_pkg::word_t       cur_word_q;
	logic [1:0]           byte_pos_q;
	logic                 out_valid_q;
	logic [7:0]           result_q;

	lsk_pkg::word_t       nw;
	lsk_pkg::word_t       word;
	lsk_pkg::window_t     load_win;
	logic                 need_load;
	logic                 can_out;
	logic [7:0]           ks;

	assign out_valid   = out_valid_q;
	assign result_byte = result_q;

	always_comb begin
		nw        = lsk_pkg::next_word(win_q);
		load_win  = {init_vector_q[63:32], init_vector_q[31:0],
			key_high_q[63:32], key_high_q[31:0],
			key_low_q[63:32], key_low_q[31:0]};
		can_out   = !out_valid_q || !out_stall;
		need_load = (state_q == ST_RUN) && head.valid && head.item.restart && !warm_done_q;
		pop       = (state_q == ST_RUN) && head.valid && can_out
			&& !(head.item.restart && !warm_done_q);
		word      = (byte_pos_q == 2'd0) ? nw : cur_word_q;
		ks        = word[{byte_pos_q, 3'b000} +: 8];
	end

	// config writes; unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q     <= '0;
			key_high_q    <= '0;
			init_vector_q <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				lsk_pkg::CFG_KEY_LOW:     key_low_q     <= cfg_data;
				lsk_pkg::CFG_KEY_HIGH:    key_high_q    <= cfg_data;
				lsk_pkg::CFG_INIT_VECTOR: init_vector_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			round_q     <= '0;
			warm_done_q <= 1'b0;
			win_q       <= '0;
			cur_word_q  <= '0;
			byte_pos_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (need_load) begin
						win_q      <= load_win;
						byte_pos_q <= '0;
						round_q    <= '0;
						state_q    <= ST_WARM;
					end else if (pop) begin
						if (byte_pos_q == 2'd0) begin
							win_q      <= {nw, win_q[lsk_pkg::WINDOW_DEPTH-1:1]};
							cur_word_q <= nw;
						end
						byte_pos_q  <= byte_pos_q + 2'd1;
						warm_done_q <= 1'b0;
					end
				end
				ST_WARM: begin
					if (round_q == CNT_W'(WARMUP_ROUNDS)) begin
						state_q     <= ST_RUN;
						warm_done_q <= 1'b1;
					end else begin
						win_q   <= {nw, win_q[lsk_pkg::WINDOW_DEPTH-1:1]};
						round_q <= round_q + 1'b1;
					end
				end
				default: state_q <= ST_RUN;
			endcase

			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= head.item.data_byte ^ ks;
		end
	end

	`LSK_NEVER(a_pop_overwrite, pop && out_valid_q && out_stall,
		"result overwritten while stalled")
	`LSK_ASSERT(a_load_pos, need_load |=> (byte_pos_q == 2'd0) && (state_q == ST_WARM),
		"restart did not realign byte position")

endmodule

// ----- src/lagged_sum_keystream_cipher_top.sv -----
// Top level of the lagged-sum keystream byte cipher.
// Depends on lsk_pkg, lsk_front and lsk_back.
// Usage:
//   Input channel (in_valid/in_stall): one request per byte, data_byte plus
//   restart. restart=1 reloads the window from key_low/key_high/init_vector
//   and runs the warm-up rounds before that byte is combined.
//   Output channel (out_valid/out_stall): one result_byte per request, in order.
//   Config port: cfg_write_en/cfg_index/cfg_data, write only, used while idle;
//   index 0 key_low, 1 key_high, 2 init_vector, others ignored.
// Timing:
//   result_byte is registered: it is valid in the cycle after the back end pops
//   its request. Throughput is one byte per cycle while the output does not
//   stall and no warm-up runs: each word from the window recurrence serves
//   four bytes and is computed in the cycle its first byte is needed. A restart
//   makes the back end load the window, run the warm-up rounds and then resume;
//   the 4-entry queue keeps taking requests meanwhile.
// Reset: clears the queue, config registers, window and byte position;
//   without a restart the keystream runs from the all-zero window.
// Stall: a stalled result holds in the output register; the back end stops,
//   the queue fills and then in_stall rises.
module lagged_sum_keystream_cipher_top #(
	parameter int WARMUP_ROUNDS = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      data_byte,
	input  logic                            restart,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      result_byte,
	input  logic                            cfg_write_en,
	input  logic [lsk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lsk_pkg::CFG_DATA_W-1:0]  cfg_data
);

	lsk_pkg::q_head_t head;   // oldest queued request
	logic             pop;    // back end consumes the head

	lsk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.restart   (restart),
		.head      (head),
		.pop       (pop)
	);

	lsk_back #(
		.WARMUP_ROUNDS (WARMUP_ROUNDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_byte  (result_byte)
	);

endmodule
